// ===== rtl/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

  localparam int HOLD_W = 16;
  localparam int DATA_W = 8;
  localparam int OP_W   = 3;
  localparam int PC_W   = 5;
  localparam int CNT_W  = 3;

  localparam logic [HOLD_W-1:0] BIT_HOLD_RST = 16'd20;
  localparam logic [HOLD_W-1:0] ACK_HOLD_RST = 16'd10;

  // command codes
  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_WAIT  = 3'd4;

  // config register indexes
  localparam logic REG_BIT_HOLD = 1'b0;
  localparam logic REG_ACK_HOLD = 1'b1;

  // SDA source select
  localparam logic [1:0] SDA_ZERO = 2'd0;
  localparam logic [1:0] SDA_ONE  = 2'd1;
  localparam logic [1:0] SDA_TX   = 2'd2;
  localparam logic [1:0] SDA_ACK  = 2'd3;

  // hold time select
  localparam logic [1:0] HOLD_ZERO = 2'd0;
  localparam logic [1:0] HOLD_BIT  = 2'd1;
  localparam logic [1:0] HOLD_ACK  = 2'd2;

  // sequencing
  localparam logic [1:0] SEQ_NEXT = 2'd0;
  localparam logic [1:0] SEQ_LOOP = 2'd1;  // jump while count != 0
  localparam logic [1:0] SEQ_BR   = 2'd2;  // jump when SDA sampled high
  localparam logic [1:0] SEQ_END  = 2'd3;

  // program layout
  localparam logic [PC_W-1:0] A_START = 5'd0;
  localparam logic [PC_W-1:0] A_STOP  = 5'd3;
  localparam logic [PC_W-1:0] A_WRITE = 5'd6;
  localparam logic [PC_W-1:0] A_READ  = 5'd9;
  localparam logic [PC_W-1:0] A_WAIT  = 5'd14;
  localparam logic [PC_W-1:0] A_LAST  = 5'd16;

  localparam logic [CNT_W-1:0] BIT_LOOPS = 3'd7;

  typedef struct packed {
    logic            scl;
    logic [1:0]      sda_sel;
    logic            drv;
    logic [1:0]      hold_sel;
    logic            rxb;
    logic            err;
    logic            last;
    logic [1:0]      seq;
    logic [PC_W-1:0] target;
  } uword_t;

  // per-phase control from sequencer to output stage
  typedef struct packed {
    logic              emit;
    logic              scl;
    logic [1:0]        sda_sel;
    logic              drv;
    logic [1:0]        hold_sel;
    logic              tx_bit;
    logic              send_ack;
    logic              err;
    logic              last;
    logic [DATA_W-1:0] rx_byte;
  } phase_ctl_t;

  function automatic uword_t uw(input logic scl, input logic [1:0] sda,
                                input logic drv, input logic [1:0] hold,
                                input logic rxb, input logic err, input logic last,
                                input logic [1:0] seq, input logic [PC_W-1:0] tgt);
    uword_t w;
    w.scl      = scl;
    w.sda_sel  = sda;
    w.drv      = drv;
    w.hold_sel = hold;
    w.rxb      = rxb;
    w.err      = err;
    w.last     = last;
    w.seq      = seq;
    w.target   = tgt;
    return w;
  endfunction

  // microcode program
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      // start
      5'd0:  w = uw(1'b1, SDA_ONE,  1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd1:  w = uw(1'b1, SDA_ZERO, 1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd2:  w = uw(1'b0, SDA_ZERO, 1'b1, HOLD_ZERO, 1'b0, 1'b0, 1'b1, SEQ_END,  A_START);
      // stop (also the failed-acknowledge tail; err gated by fail flag)
      5'd3:  w = uw(1'b0, SDA_ZERO, 1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd4:  w = uw(1'b1, SDA_ZERO, 1'b1, HOLD_ZERO, 1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd5:  w = uw(1'b1, SDA_ONE,  1'b1, HOLD_BIT,  1'b0, 1'b1, 1'b1, SEQ_END,  A_START);
      // write byte
      5'd6:  w = uw(1'b0, SDA_TX,   1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd7:  w = uw(1'b1, SDA_TX,   1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd8:  w = uw(1'b0, SDA_TX,   1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b1, SEQ_LOOP, A_WRITE);
      // read byte
      5'd9:  w = uw(1'b0, SDA_ONE,  1'b0, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd10: w = uw(1'b1, SDA_ONE,  1'b0, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_LOOP, A_READ);
      5'd11: w = uw(1'b0, SDA_ACK,  1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd12: w = uw(1'b1, SDA_ACK,  1'b1, HOLD_BIT,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd13: w = uw(1'b0, SDA_ACK,  1'b1, HOLD_ZERO, 1'b1, 1'b0, 1'b1, SEQ_END,  A_START);
      // wait acknowledge
      5'd14: w = uw(1'b0, SDA_ONE,  1'b0, HOLD_ACK,  1'b0, 1'b0, 1'b0, SEQ_NEXT, A_START);
      5'd15: w = uw(1'b1, SDA_ONE,  1'b0, HOLD_ACK,  1'b0, 1'b0, 1'b0, SEQ_BR,   A_STOP);
      5'd16: w = uw(1'b0, SDA_ONE,  1'b0, HOLD_ZERO, 1'b0, 1'b0, 1'b1, SEQ_END,  A_START);
      default: w = uw(1'b0, SDA_ONE, 1'b0, HOLD_ZERO, 1'b0, 1'b0, 1'b1, SEQ_END, A_START);
    endcase
    return w;
  endfunction

  // entry point per command; bit PC_W flags a known command
  function automatic logic [PC_W:0] op_entry(input logic [OP_W-1:0] op);
    logic [PC_W:0] e;
    unique case (op)
      OP_START: e = {1'b1, A_START};
      OP_STOP:  e = {1'b1, A_STOP};
      OP_WRITE: e = {1'b1, A_WRITE};
      OP_READ:  e = {1'b1, A_READ};
      OP_WAIT:  e = {1'b1, A_WAIT};
      default:  e = {1'b0, A_START};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cms_ctrl.sv =====
`default_nettype none

module i2cms_ctrl
  import i2cms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [DATA_W-1:0] tx_data,
  input  wire logic              send_ack,
  input  wire logic [DATA_W-1:0] rx_bits,
  input  wire logic              ack_level,
  input  wire logic              out_ready,
  output phase_ctl_t             ctl
);

  logic              busy;
  logic [PC_W-1:0]   pc;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] tx_sh;
  logic              ack_r;
  logic [DATA_W-1:0] rx_r;
  logic              lvl_r;
  logic              fail;

  uword_t        word;
  logic          step;
  logic          take;
  logic [PC_W:0] entry;
  logic          cnt_zero;
  logic          fin;

  assign word     = ucode_rom(pc);
  assign step     = busy && out_ready;
  assign cnt_zero = (cnt == '0);
  // final phase of the command: a looping word only ends on its last pass
  assign fin      = word.last && (word.seq != SEQ_LOOP || cnt_zero);
  // last phase leaves the sequencer free for a new command at the same edge
  assign in_stall = busy && !(step && fin);
  assign take     = in_valid && !in_stall;
  assign entry    = op_entry(operation);

  always_comb begin
    ctl.emit     = step;
    ctl.scl      = word.scl;
    ctl.sda_sel  = word.sda_sel;
    ctl.drv      = word.drv;
    ctl.hold_sel = word.hold_sel;
    ctl.tx_bit   = tx_sh[DATA_W-1];
    ctl.send_ack = ack_r;
    ctl.err      = word.err && fail;
    ctl.last     = fin;
    ctl.rx_byte  = word.rxb ? rx_r : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fail <= 1'b0;
      pc   <= A_START;
      cnt  <= '0;
    end else if (take) begin
      busy  <= entry[PC_W];
      pc    <= entry[PC_W-1:0];
      cnt   <= BIT_LOOPS;
      fail  <= 1'b0;
      tx_sh <= tx_data;
      ack_r <= send_ack;
      rx_r  <= rx_bits;
      lvl_r <= ack_level;
    end else if (step) begin
      if (fin) begin
        busy <= 1'b0;
      end
      unique case (word.seq)
        SEQ_NEXT: pc <= pc + 1'b1;
        SEQ_LOOP: begin
          tx_sh <= {tx_sh[DATA_W-2:0], 1'b0};
          if (!cnt_zero) begin
            cnt <= cnt - 1'b1;
            pc  <= word.target;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        SEQ_BR: begin
          if (lvl_r) begin
            pc   <= word.target;
            fail <= 1'b1;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        SEQ_END: pc <= A_START;
      endcase
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) busy |-> pc <= A_LAST)
    else $error("pc outside program");
  a_idle_open: assert property (@(posedge clk) disable iff (rst) !busy |-> !in_stall)
    else $error("stall while idle");
  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && ctl.err |-> ctl.last)
    else $error("error flag off the last phase");

endmodule

`default_nettype wire

// ===== rtl/i2cms_phase_out.sv =====
`default_nettype none

module i2cms_phase_out
  import i2cms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [HOLD_W-1:0] cfg_data,
  input  wire phase_ctl_t        ctl,
  output logic                   out_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   scl_level,
  output logic                   sda_level,
  output logic                   sda_driven,
  output logic [HOLD_W-1:0]      hold_time,
  output logic [DATA_W-1:0]      rx_byte,
  output logic                   ack_error,
  output logic                   last_phase
);

  logic [HOLD_W-1:0] bit_hold;
  logic [HOLD_W-1:0] ack_hold;
  logic              sda_mux;
  logic [HOLD_W-1:0] hold_mux;

  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    case (ctl.sda_sel)
      SDA_ZERO: sda_mux = 1'b0;
      SDA_ONE:  sda_mux = 1'b1;
      SDA_TX:   sda_mux = ctl.tx_bit;
      SDA_ACK:  sda_mux = !ctl.send_ack;
      default:  sda_mux = 1'b1;
    endcase
    case (ctl.hold_sel)
      HOLD_BIT: hold_mux = bit_hold;
      HOLD_ACK: hold_mux = ack_hold;
      default:  hold_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bit_hold  <= BIT_HOLD_RST;
      ack_hold  <= ACK_HOLD_RST;
    end else begin
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_BIT_HOLD) begin
          bit_hold <= cfg_data;
        end else begin
          ack_hold <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      scl_level  <= ctl.scl;
      sda_level  <= sda_mux;
      sda_driven <= ctl.drv;
      hold_time  <= hold_mux;
      rx_byte    <= ctl.rx_byte;
      ack_error  <= ctl.err;
      last_phase <= ctl.last;
    end
  end

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled beat dropped");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> out_ready)
    else $error("phase emitted into full output register");
  a_released_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_driven |-> sda_level)
    else $error("released SDA not reported high");

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_sequencer_unit.sv =====
// I2C master bit sequencer.
// Input channel (in_valid/in_stall): one bus command per beat - operation, tx_data,
//   send_ack, rx_bits, ack_level. Output channel (out_valid/out_stall): one bus
//   phase per beat - SCL, SDA level, SDA drive enable, hold time, rx_byte,
//   ack_error; last_phase marks the final beat of a command.
// Beats per command: start 3, stop 3, write 24, read 19, wait-ack 3 (acked) or 5
//   (no ack, runs the stop tail with ack_error). Unknown codes give no beats.
// The command is registered in the sequencer; its phases then pass through the output register.
// Throughput: one phase per cycle while the output is not stalled, from a microcoded
//   sequencer (program ROM, step counter, bit loop counter); the next command is
//   taken in the cycle of the current last phase.
// Config: cfg_we writes bit_hold (index 0) or ack_hold (index 1) from cfg_data;
//   write only while idle.
// Reset: sequencer idle, output empty, bit_hold = 20, ack_hold = 10.
// Stall: a stalled phase holds in the output register; the sequencer waits and
//   in_stall stays high until the command's last phase has been emitted.
`default_nettype none

module i2c_master_bit_sequencer_unit
  import i2cms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [HOLD_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [DATA_W-1:0] tx_data,
  input  wire logic              send_ack,
  input  wire logic [DATA_W-1:0] rx_bits,
  input  wire logic              ack_level,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   scl_level,
  output logic                   sda_level,
  output logic                   sda_driven,
  output logic [HOLD_W-1:0]      hold_time,
  output logic [DATA_W-1:0]      rx_byte,
  output logic                   ack_error,
  output logic                   last_phase
);

  phase_ctl_t ctl;
  logic       out_ready;

  // program sequencer
  i2cms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .tx_data   (tx_data),
    .send_ack  (send_ack),
    .rx_bits   (rx_bits),
    .ack_level (ack_level),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // field muxing, hold registers, output register
  i2cms_phase_out u_out (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_driven (sda_driven),
    .hold_time  (hold_time),
    .rx_byte    (rx_byte),
    .ack_error  (ack_error),
    .last_phase (last_phase)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
import i2cms_pkg::*;

// One bus phase as the block reports it on its output channel.
typedef struct {
  logic              scl;
  logic              sda;
  logic              drv;
  logic [HOLD_W-1:0] hold;
  logic [DATA_W-1:0] rxb;
  logic              err;
  logic              last;
} bus_phase_t;

// Expands each accepted command into its bus phases and checks the output
// beats against them in order.
class bus_phase_board;
  bus_phase_t        pending_phases[$];
  logic [HOLD_W-1:0] bit_hold;
  logic [HOLD_W-1:0] ack_hold;
  int                errors;

  function new();
    bit_hold = BIT_HOLD_RST;
    ack_hold = ACK_HOLD_RST;
    errors   = 0;
  endfunction

  function void set_hold(logic idx, logic [HOLD_W-1:0] val);
    if (idx == REG_BIT_HOLD) begin
      bit_hold = val;
    end else begin
      ack_hold = val;
    end
  endfunction

  function void push_phase(logic scl, logic sda, logic drv, logic [HOLD_W-1:0] hold,
                           logic [DATA_W-1:0] rxb, logic err, logic last);
    bus_phase_t p;
    p.scl  = scl;
    p.sda  = sda;
    p.drv  = drv;
    p.hold = hold;
    p.rxb  = rxb;
    p.err  = err;
    p.last = last;
    pending_phases.push_back(p);
  endfunction

  // SDA rises while SCL is high; the middle phase is passed with no delay.
  function void push_stop(logic err);
    push_phase(1'b0, 1'b0, 1'b1, bit_hold, '0, 1'b0, 1'b0);
    push_phase(1'b1, 1'b0, 1'b1, '0,       '0, 1'b0, 1'b0);
    push_phase(1'b1, 1'b1, 1'b1, bit_hold, '0, err,  1'b1);
  endfunction

  function void note_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] tx, logic send_ack,
                             logic [DATA_W-1:0] rx, logic ack_level);
    int   i;
    logic lev;
    lev = ~send_ack;
    case (op)
      OP_START: begin
        push_phase(1'b1, 1'b1, 1'b1, bit_hold, '0, 1'b0, 1'b0);
        push_phase(1'b1, 1'b0, 1'b1, bit_hold, '0, 1'b0, 1'b0);
        push_phase(1'b0, 1'b0, 1'b1, '0,       '0, 1'b0, 1'b1);
      end
      OP_STOP: push_stop(1'b0);
      OP_WRITE: begin
        for (i = 7; i >= 0; i--) begin
          push_phase(1'b0, tx[i], 1'b1, bit_hold, '0, 1'b0, 1'b0);
          push_phase(1'b1, tx[i], 1'b1, bit_hold, '0, 1'b0, 1'b0);
          push_phase(1'b0, tx[i], 1'b1, bit_hold, '0, 1'b0, i == 0);
        end
      end
      OP_READ: begin
        // SDA released: pull-up level 1
        for (i = 0; i < 8; i++) begin
          push_phase(1'b0, 1'b1, 1'b0, bit_hold, '0, 1'b0, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, bit_hold, '0, 1'b0, 1'b0);
        end
        push_phase(1'b0, lev, 1'b1, bit_hold, '0, 1'b0, 1'b0);
        push_phase(1'b1, lev, 1'b1, bit_hold, '0, 1'b0, 1'b0);
        push_phase(1'b0, lev, 1'b1, '0,       rx, 1'b0, 1'b1);
      end
      OP_WAIT: begin
        push_phase(1'b0, 1'b1, 1'b0, ack_hold, '0, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0, ack_hold, '0, 1'b0, 1'b0);
        if (ack_level == 1'b0) begin
          push_phase(1'b0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          push_stop(1'b1);
        end
      end
      default: ;  // unknown codes give no phases
    endcase
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_phase(bus_phase_t got);
    bus_phase_t want;
    if (pending_phases.size() == 0) begin
      $error("phase beat with nothing expected");
      errors++;
    end else begin
      want = pending_phases.pop_front();
      compare_field("scl_level",  want.scl,  got.scl);
      compare_field("sda_level",  want.sda,  got.sda);
      compare_field("sda_driven", want.drv,  got.drv);
      compare_field("hold_time",  want.hold, got.hold);
      compare_field("rx_byte",    want.rxb,  got.rxb);
      compare_field("ack_error",  want.err,  got.err);
      compare_field("last_phase", want.last, got.last);
    end
  endfunction

  function int pending();
    return pending_phases.size();
  endfunction
endclass

module testbench;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [HOLD_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] tx_data;
  logic              send_ack;
  logic [DATA_W-1:0] rx_bits;
  logic              ack_level;
  logic              out_valid;
  logic              out_stall;
  logic              scl_level;
  logic              sda_level;
  logic              sda_driven;
  logic [HOLD_W-1:0] hold_time;
  logic [DATA_W-1:0] rx_byte;
  logic              ack_error;
  logic              last_phase;

  bus_phase_board board;

  // idle_on: random gaps/stalls on both sides; cleared for one quiet phase.
  // hold_off_req: asks the receiver for one long stall to back up the block.
  logic idle_on;
  logic hold_off_req;
  int   cmds_sent;  // known commands accepted in the current random run

  i2c_master_bit_sequencer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .tx_data    (tx_data),
    .send_ack   (send_ack),
    .rx_bits    (rx_bits),
    .ack_level  (ack_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_driven (sda_driven),
    .hold_time  (hold_time),
    .rx_byte    (rx_byte),
    .ack_error  (ack_error),
    .last_phase (last_phase)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop. Slowest legal run is roughly 320 writes x 24 beats with stalls
  // and gaps, plus the long hold-off; this is many times that.
  initial begin
    #800000;
    $display("testbench failed");
    $finish;
  end

  // Receiver: stall decided at each falling edge. A hold-off request keeps
  // stall high while the sender keeps offering.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall    = 1'b1;
        repeat (300) @(negedge clk);
      end
      out_stall = idle_on && ($urandom_range(99) < 22);
    end
  end

  // Output monitor: a beat moves at a rising edge with valid high, stall low.
  always @(posedge clk) begin
    bus_phase_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.scl  = scl_level;
      got.sda  = sda_level;
      got.drv  = sda_driven;
      got.hold = hold_time;
      got.rxb  = rx_byte;
      got.err  = ack_error;
      got.last = last_phase;
      board.check_phase(got);
    end
  end

  // Offer one command; returns after the beat has been taken. Payload is only
  // changed when valid is raised, so a stalled beat stays put.
  task automatic send_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] tx, logic ack,
                              logic [DATA_W-1:0] rx, logic lvl);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    operation = op;
    tx_data   = tx;
    send_ack  = ack;
    rx_bits   = rx;
    ack_level = lvl;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_command(op, tx, ack, rx, lvl);
    if (op <= OP_WAIT) cmds_sent++;
  endtask

  // Command with every unused field randomized.
  task automatic send_op(logic [OP_W-1:0] op);
    send_command(op, DATA_W'($urandom_range(255)), 1'($urandom_range(1)),
                 DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Let the block go idle: all phases out, then a further wait covering a command
  // that produced nothing.
  task automatic drain();
    int n;
    @(negedge clk);
    in_valid = 1'b0;
    for (n = 0; n < 100000 && board.pending() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(logic [HOLD_W-1:0] bh, logic [HOLD_W-1:0] ah);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = REG_BIT_HOLD;
    cfg_data  = bh;
    @(posedge clk);
    board.set_hold(REG_BIT_HOLD, bh);
    @(negedge clk);
    cfg_index = REG_ACK_HOLD;
    cfg_data  = ah;
    @(posedge clk);
    board.set_hold(REG_ACK_HOLD, ah);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed transfers (start, address, ack, data bytes, stop),
  // some random noise including unknown codes.
  task automatic run_random(int count);
    int nbytes;
    int b;
    cmds_sent = 0;
    while (cmds_sent < count) begin
      if ($urandom_range(99) < 80) begin
        send_op(OP_START);
        send_command(OP_WRITE, DATA_W'($urandom_range(255)), 1'($urandom_range(1)),
                     DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
        send_command(OP_WAIT, DATA_W'($urandom_range(255)), 1'($urandom_range(1)),
                     DATA_W'($urandom_range(255)), $urandom_range(9) == 0);
        nbytes = $urandom_range(1, 4);
        for (b = 0; b < nbytes; b++) begin
          if ($urandom_range(1)) begin
            send_op(OP_READ);
          end else begin
            send_op(OP_WRITE);
            send_command(OP_WAIT, DATA_W'($urandom_range(255)), 1'($urandom_range(1)),
                         DATA_W'($urandom_range(255)), $urandom_range(7) == 0);
          end
        end
        send_op(OP_STOP);
      end else begin
        send_op(OP_W'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    int s;
    board        = new();
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    cmds_sent    = 0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_BIT_HOLD;
    cfg_data     = '0;
    in_valid     = 1'b0;
    operation    = OP_START;
    tx_data      = '0;
    send_ack     = 1'b0;
    rx_bits      = '0;
    ack_level    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, at reset hold values: each command, byte extremes,
    // ack/nack on read, acked and failed wait, unknown codes.
    send_command(OP_START, 8'hff, 1'b1, 8'hff, 1'b1);
    send_command(OP_WRITE, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_WAIT,  8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_WRITE, 8'hff, 1'b1, 8'hff, 1'b1);
    send_command(OP_WAIT,  8'hff, 1'b1, 8'hff, 1'b1);  // no ack: stop tail
    send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_WRITE, 8'ha5, 1'b0, 8'h5a, 1'b0);
    send_command(OP_WAIT,  8'h5a, 1'b1, 8'ha5, 1'b0);
    send_command(OP_READ,  8'h00, 1'b1, 8'hff, 1'b0);  // ACK low
    send_command(OP_READ,  8'hff, 1'b0, 8'h00, 1'b1);  // NACK high
    send_command(OP_READ,  8'h3c, 1'b1, 8'h96, 1'b1);
    send_command(OP_READ,  8'hc3, 1'b0, 8'h69, 1'b0);
    send_command(OP_STOP,  8'hff, 1'b1, 8'hff, 1'b1);
    send_command(3'd5,     8'h12, 1'b1, 8'h34, 1'b1);  // unknown codes: no phases
    send_command(3'd6,     8'hff, 1'b0, 8'h00, 1'b0);
    send_command(3'd7,     8'h00, 1'b1, 8'hff, 1'b1);
    send_command(OP_START, 8'h55, 1'b0, 8'haa, 1'b1);
    send_command(OP_WRITE, 8'h80, 1'b0, 8'h01, 1'b0);
    send_command(OP_WAIT,  8'h01, 1'b0, 8'h80, 1'b1);
    send_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
    drain();

    // Random phases over several hold settings, extremes and zero included.
    for (s = 0; s < 5; s++) begin
      case (s)
        0: apply_setting(16'hffff, 16'h0001);
        1: apply_setting(16'h0001, 16'hffff);
        2: apply_setting(16'h0000, 16'h0000);  // zero holds pass straight through
        default: apply_setting(HOLD_W'($urandom_range(1, 65535)),
                               HOLD_W'($urandom_range(1, 65535)));
      endcase
      idle_on = (s != 1);             // one phase runs flat out on both sides
      if (s == 3) hold_off_req = 1'b1;
      run_random(64);
      drain();
      idle_on = 1'b1;
    end

    if (board.pending() != 0) begin
      $error("%0d expected phases never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
